>>> rtl/core/siu_pkg.sv
// Shared types, widths and helper functions of the segment intersection unit.
package siu_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 15;
    localparam int DIFF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int CROSS_W   = 33;
    localparam int NUM_W     = 49;
    localparam int DEN_W     = 32;
    localparam int QUO_W     = 17;
    localparam int PTD_W     = 45;
    localparam int CMP_W     = 50;
    localparam int ONE_SHIFT = 16;
    localparam int OTOL_W    = 16;
    localparam int CTOL_W    = 8;
    localparam int PTOL_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int INFL_W    = 3;

    // Defaults for top level parameters
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 8;

    // Register reset values
    localparam logic [OTOL_W-1:0] OTOL_RST = OTOL_W'(1);
    localparam logic [CTOL_W-1:0] CTOL_RST = CTOL_W'(1);
    localparam logic [PTOL_W-1:0] PTOL_RST = PTOL_W'(1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIENT_TOL = 2'd0,
        REG_COORD_TOL  = 2'd1,
        REG_PARAM_TOL  = 2'd2
    } t_reg_idx;

    // Orientation result inside the tolerance band
    typedef enum logic [1:0] {
        OR_ZERO = 2'b00,
        OR_POS  = 2'b01,
        OR_NEG  = 2'b10
    } t_orient;

    typedef struct packed {
        logic [OTOL_W-1:0] orient_tol;
        logic [CTOL_W-1:0] coord_tol;
        logic [PTOL_W-1:0] param_tol;
    } t_cfg;

    // One classified pair, waiting for the point division
    typedef struct packed {
        logic                      hit;
        logic                      pvalid;
        logic signed [NUM_W-1:0]   num_x;
        logic signed [NUM_W-1:0]   num_y;
        logic        [DEN_W-1:0]   den;
        logic        [COORD_W-1:0] p1_x;
        logic        [COORD_W-1:0] p1_y;
    } t_qentry;

    // Signed difference of two coordinates
    function automatic logic signed [DIFF_W-1:0] coord_sub(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // c within [min(a,b)-tol, max(a,b)+tol]
    function automatic logic in_span(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] c,
        input logic [CTOL_W-1:0]  tol
    );
        logic [COORD_W:0] lo;
        logic [COORD_W:0] hi;
        logic [COORD_W:0] ce;
        logic [COORD_W:0] tl;
        lo = (a < b) ? {1'b0, a} : {1'b0, b};
        hi = (a < b) ? {1'b0, b} : {1'b0, a};
        ce = {1'b0, c};
        tl = (COORD_W+1)'(tol);
        return (lo <= ce + tl) && (ce <= hi + tl);
    endfunction

    // Sign of a cross product with a dead band of +-tol
    function automatic t_orient orient_band(
        input logic signed [CROSS_W-1:0] v,
        input logic        [OTOL_W-1:0]  tol
    );
        logic signed [CROSS_W-1:0] t;
        t = $signed(CROSS_W'(tol));
        if (v > t) begin
            return OR_POS;
        end else if (v < -t) begin
            return OR_NEG;
        end
        return OR_ZERO;
    endfunction

endpackage

>>> rtl/core/siu_front.sv
// Front pipeline: cross products, orientation tests and parameter range checks.
module siu_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  siu_pkg::t_cfg                  i_cfg,
    input  logic                           i_accept,
    input  logic [siu_pkg::COORD_W-1:0]    i_p1_x,
    input  logic [siu_pkg::COORD_W-1:0]    i_p1_y,
    input  logic [siu_pkg::COORD_W-1:0]    i_p2_x,
    input  logic [siu_pkg::COORD_W-1:0]    i_p2_y,
    input  logic [siu_pkg::COORD_W-1:0]    i_q1_x,
    input  logic [siu_pkg::COORD_W-1:0]    i_q1_y,
    input  logic [siu_pkg::COORD_W-1:0]    i_q2_x,
    input  logic [siu_pkg::COORD_W-1:0]    i_q2_y,
    output logic                           o_push,
    output siu_pkg::t_qentry               o_entry,
    output logic [siu_pkg::INFL_W-1:0]     o_inflight
);
    import siu_pkg::*;

    // Stage 1: differences and collinear box tests
    logic                       r1_vld;
    logic signed [DIFF_W-1:0]   r1_rx, r1_ry, r1_sx, r1_sy, r1_qx, r1_qy;
    logic signed [DIFF_W-1:0]   r1_wx, r1_wy, r1_vx, r1_vy;
    logic [3:0]                 r1_on;
    logic [COORD_W-1:0]         r1_p1x, r1_p1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rx  <= coord_sub(i_p2_x, i_p1_x);
        r1_ry  <= coord_sub(i_p2_y, i_p1_y);
        r1_sx  <= coord_sub(i_q2_x, i_q1_x);
        r1_sy  <= coord_sub(i_q2_y, i_q1_y);
        r1_qx  <= coord_sub(i_q1_x, i_p1_x);
        r1_qy  <= coord_sub(i_q1_y, i_p1_y);
        r1_wx  <= coord_sub(i_q2_x, i_p1_x);
        r1_wy  <= coord_sub(i_q2_y, i_p1_y);
        r1_vx  <= coord_sub(i_p2_x, i_q1_x);
        r1_vy  <= coord_sub(i_p2_y, i_q1_y);
        r1_on[0] <= in_span(i_p1_x, i_p2_x, i_q1_x, i_cfg.coord_tol)
                 && in_span(i_p1_y, i_p2_y, i_q1_y, i_cfg.coord_tol);
        r1_on[1] <= in_span(i_p1_x, i_p2_x, i_q2_x, i_cfg.coord_tol)
                 && in_span(i_p1_y, i_p2_y, i_q2_y, i_cfg.coord_tol);
        r1_on[2] <= in_span(i_q1_x, i_q2_x, i_p1_x, i_cfg.coord_tol)
                 && in_span(i_q1_y, i_q2_y, i_p1_y, i_cfg.coord_tol);
        r1_on[3] <= in_span(i_q1_x, i_q2_x, i_p2_x, i_cfg.coord_tol)
                 && in_span(i_q1_y, i_q2_y, i_p2_y, i_cfg.coord_tol);
        r1_p1x <= i_p1_x;
        r1_p1y <= i_p1_y;
    end

    // Stage 2: partial products
    logic                       r2_vld;
    logic signed [PROD_W-1:0]   r2_den_a, r2_den_b, r2_tn_a, r2_tn_b, r2_un_a, r2_un_b;
    logic signed [PROD_W-1:0]   r2_c2_a, r2_c2_b, r2_c4_a, r2_c4_b;
    logic signed [DIFF_W-1:0]   r2_rx, r2_ry;
    logic [3:0]                 r2_on;
    logic [COORD_W-1:0]         r2_p1x, r2_p1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_den_a <= r1_rx * r1_sy;
        r2_den_b <= r1_ry * r1_sx;
        r2_tn_a  <= r1_qx * r1_sy;
        r2_tn_b  <= r1_qy * r1_sx;
        r2_un_a  <= r1_qx * r1_ry;
        r2_un_b  <= r1_qy * r1_rx;
        r2_c2_a  <= r1_rx * r1_wy;
        r2_c2_b  <= r1_ry * r1_wx;
        r2_c4_a  <= r1_sx * r1_vy;
        r2_c4_b  <= r1_sy * r1_vx;
        r2_rx    <= r1_rx;
        r2_ry    <= r1_ry;
        r2_on    <= r1_on;
        r2_p1x   <= r1_p1x;
        r2_p1y   <= r1_p1y;
    end

    // Stage 3: cross products
    logic                       r3_vld;
    logic signed [CROSS_W-1:0]  r3_den, r3_tn, r3_un, r3_c2, r3_c4;
    logic signed [DIFF_W-1:0]   r3_rx, r3_ry;
    logic [3:0]                 r3_on;
    logic [COORD_W-1:0]         r3_p1x, r3_p1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_den <= CROSS_W'(r2_den_a) - CROSS_W'(r2_den_b);
        r3_tn  <= CROSS_W'(r2_tn_a) - CROSS_W'(r2_tn_b);
        r3_un  <= CROSS_W'(r2_un_a) - CROSS_W'(r2_un_b);
        r3_c2  <= CROSS_W'(r2_c2_a) - CROSS_W'(r2_c2_b);
        r3_c4  <= CROSS_W'(r2_c4_a) - CROSS_W'(r2_c4_b);
        r3_rx  <= r2_rx;
        r3_ry  <= r2_ry;
        r3_on  <= r2_on;
        r3_p1x <= r2_p1x;
        r3_p1y <= r2_p1y;
    end

    // Stage 4: orientation classes, touch decision, sign normalization.
    // turn(p1,p2,q1) is -un and turn(q1,q2,p1) is tn.
    t_orient                    n_o1, n_o2, n_o3, n_o4;
    logic                       n_hit;
    logic                       n_neg;
    logic                       r4_vld;
    logic                       r4_hit;
    logic signed [CROSS_W-1:0]  r4_den, r4_tn, r4_un;
    logic signed [DIFF_W-1:0]   r4_rx, r4_ry;
    logic [COORD_W-1:0]         r4_p1x, r4_p1y;

    always_comb begin
        n_o1  = orient_band(-r3_un, i_cfg.orient_tol);
        n_o2  = orient_band(r3_c2, i_cfg.orient_tol);
        n_o3  = orient_band(r3_tn, i_cfg.orient_tol);
        n_o4  = orient_band(r3_c4, i_cfg.orient_tol);
        n_hit = ((n_o1 != n_o2) && (n_o3 != n_o4))
             || ((n_o1 == OR_ZERO) && r3_on[0])
             || ((n_o2 == OR_ZERO) && r3_on[1])
             || ((n_o3 == OR_ZERO) && r3_on[2])
             || ((n_o4 == OR_ZERO) && r3_on[3]);
        n_neg = r3_den[CROSS_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_hit <= n_hit;
        r4_den <= n_neg ? -r3_den : r3_den;
        r4_tn  <= n_neg ? -r3_tn : r3_tn;
        r4_un  <= n_neg ? -r3_un : r3_un;
        r4_rx  <= r3_rx;
        r4_ry  <= r3_ry;
        r4_p1x <= r3_p1x;
        r4_p1y <= r3_p1y;
    end

    // Stage 5: tolerance product and point numerators
    logic                       r5_vld;
    logic                       r5_hit;
    logic signed [PTD_W-1:0]    r5_ptden;
    logic signed [NUM_W-1:0]    r5_numx, r5_numy;
    logic signed [CROSS_W-1:0]  r5_den, r5_tn, r5_un;
    logic [COORD_W-1:0]         r5_p1x, r5_p1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ptden <= $signed({1'b0, i_cfg.param_tol}) * r4_den;
        r5_numx  <= r4_tn * r4_rx;
        r5_numy  <= r4_tn * r4_ry;
        r5_hit   <= r4_hit;
        r5_den   <= r4_den;
        r5_tn    <= r4_tn;
        r5_un    <= r4_un;
        r5_p1x   <= r4_p1x;
        r5_p1y   <= r4_p1y;
    end

    // Range tests -tol*den <= n*2^16 <= (2^16+tol)*den, no division
    logic signed [CMP_W-1:0] n_lo, n_hi, n_st, n_su;
    logic                    n_den_ok, n_t_ok, n_u_ok;

    always_comb begin
        n_lo     = -CMP_W'(r5_ptden);
        n_hi     = CMP_W'($signed({r5_den, ONE_SHIFT'(0)})) + CMP_W'(r5_ptden);
        n_st     = CMP_W'($signed({r5_tn, ONE_SHIFT'(0)}));
        n_su     = CMP_W'($signed({r5_un, ONE_SHIFT'(0)}));
        n_den_ok = r5_den > $signed(CROSS_W'(i_cfg.orient_tol));
        n_t_ok   = (n_st >= n_lo) && (n_st <= n_hi);
        n_u_ok   = (n_su >= n_lo) && (n_su <= n_hi);
    end

    assign o_push         = r5_vld;
    assign o_entry.hit    = r5_hit;
    assign o_entry.pvalid = n_den_ok && n_t_ok && n_u_ok;
    assign o_entry.num_x  = r5_numx;
    assign o_entry.num_y  = r5_numy;
    assign o_entry.den    = r5_den[DEN_W-1:0];
    assign o_entry.p1_x   = r5_p1x;
    assign o_entry.p1_y   = r5_p1y;
    assign o_inflight     = INFL_W'($countones({r1_vld, r2_vld, r3_vld, r4_vld, r5_vld}));

endmodule

>>> rtl/core/siu_queue.sv
// Short FIFO between the front and back pipelines.
module siu_queue #(
    parameter int DEPTH = siu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  siu_pkg::t_qentry              i_entry,
    input  logic                          i_pop,
    output logic                          o_empty,
    output siu_pkg::t_qentry              o_entry,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import siu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    t_qentry            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_count;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == CNT_W'(DEPTH)) |-> i_pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

>>> rtl/core/siu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module siu_div #(
    parameter int NUM_W = siu_pkg::NUM_W,
    parameter int DEN_W = siu_pkg::DEN_W,
    parameter int QUO_W = siu_pkg::QUO_W,
    parameter int TAG_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output logic [TAG_W-1:0]  o_tag
);

    logic              s_vld [QUO_W+1];
    logic [NUM_W-1:0]  s_rem [QUO_W+1];
    logic [DEN_W-1:0]  s_den [QUO_W+1];
    logic [QUO_W-1:0]  s_quo [QUO_W+1];
    logic [TAG_W-1:0]  s_tag [QUO_W+1];

    assign s_vld[0] = i_vld;
    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;
    assign s_tag[0] = i_tag;

    // Stage g settles quotient bit QUO_W-g
    for (genvar g = 1; g <= QUO_W; g++) begin : g_stage
        localparam int B = QUO_W - g;
        logic [NUM_W:0]    n_diff;
        logic              n_ge;
        logic              r_vld;
        logic [NUM_W-1:0]  r_rem;
        logic [DEN_W-1:0]  r_den;
        logic [QUO_W-1:0]  r_quo;
        logic [TAG_W-1:0]  r_tag;

        assign n_diff = {1'b0, s_rem[g-1]} - ((NUM_W+1)'(s_den[g-1]) << B);
        assign n_ge   = ~n_diff[NUM_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_ge ? n_diff[NUM_W-1:0] : s_rem[g-1];
            r_den <= s_den[g-1];
            r_quo <= s_quo[g-1] | (QUO_W'(n_ge) << B);
            r_tag <= s_tag[g-1];
        end

        assign s_vld[g] = r_vld;
        assign s_rem[g] = r_rem;
        assign s_den[g] = r_den;
        assign s_quo[g] = r_quo;
        assign s_tag[g] = r_tag;
    end

    assign o_vld = s_vld[QUO_W];
    assign o_quo = s_quo[QUO_W];
    assign o_tag = s_tag[QUO_W];

endmodule

>>> rtl/core/siu_back.sv
// Back pipeline: rounded point division, saturation and result register.
module siu_back #(
    parameter int COORD_FRAC_BITS = siu_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  siu_pkg::t_qentry             i_entry,
    output logic                         o_done,
    output logic                         o_crosses,
    output logic                         o_point_valid,
    output logic [siu_pkg::COORD_W-1:0]  o_cross_x,
    output logic [siu_pkg::COORD_W-1:0]  o_cross_y
);
    import siu_pkg::*;

    localparam int CEIL_RAW = 100 << COORD_FRAC_BITS;
    localparam logic [COORD_W-1:0] CEIL = COORD_W'((CEIL_RAW < 32767) ? CEIL_RAW : 32767);
    localparam int SUM_W  = QUO_W + 2;
    localparam int TAGX_W = 3 + COORD_W;
    localparam int TAGY_W = 1 + COORD_W;

    // Entry: sign and magnitude, plus half the divisor for rounding
    logic               n_sgnx, n_sgny;
    logic [NUM_W-1:0]   n_magx, n_magy;
    logic               r0_vld;
    logic [NUM_W-1:0]   r0_nx, r0_ny;
    logic [DEN_W-1:0]   r0_den;
    logic [TAGX_W-1:0]  r0_tagx;
    logic [TAGY_W-1:0]  r0_tagy;

    always_comb begin
        n_sgnx = i_entry.num_x[NUM_W-1];
        n_sgny = i_entry.num_y[NUM_W-1];
        n_magx = n_sgnx ? -i_entry.num_x : i_entry.num_x;
        n_magy = n_sgny ? -i_entry.num_y : i_entry.num_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_nx   <= n_magx + NUM_W'(i_entry.den >> 1);
        r0_ny   <= n_magy + NUM_W'(i_entry.den >> 1);
        r0_den  <= i_entry.den;
        r0_tagx <= {i_entry.hit, i_entry.pvalid, n_sgnx, i_entry.p1_x};
        r0_tagy <= {n_sgny, i_entry.p1_y};
    end

    // Two dividers in lockstep
    logic               w_vld, w_vld_y;
    logic [QUO_W-1:0]   w_qx, w_qy;
    logic [TAGX_W-1:0]  w_tagx;
    logic [TAGY_W-1:0]  w_tagy;

    siu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .TAG_W(TAGX_W)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r0_vld),
        .i_num  (r0_nx),
        .i_den  (r0_den),
        .i_tag  (r0_tagx),
        .o_vld  (w_vld),
        .o_quo  (w_qx),
        .o_tag  (w_tagx)
    );

    siu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .TAG_W(TAGY_W)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r0_vld),
        .i_num  (r0_ny),
        .i_den  (r0_den),
        .i_tag  (r0_tagy),
        .o_vld  (w_vld_y),
        .o_quo  (w_qy),
        .o_tag  (w_tagy)
    );

    // Offset from p1, then clamp to the coordinate range
    function automatic logic [COORD_W-1:0] place(
        input logic [COORD_W-1:0] p,
        input logic               sgn,
        input logic [QUO_W-1:0]   q
    );
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] s;
        d = $signed({2'b00, q});
        s = $signed(SUM_W'(p)) + (sgn ? -d : d);
        if (s < 0) begin
            return '0;
        end else if (s > $signed(SUM_W'(CEIL))) begin
            return CEIL;
        end
        return s[COORD_W-1:0];
    endfunction

    logic n_hit, n_pv;
    assign n_hit = w_tagx[TAGX_W-1];
    assign n_pv  = w_tagx[TAGX_W-2];

    // Result register, strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_vld && w_vld_y;
        end
    end

    always_ff @(posedge i_clk) begin
        o_crosses     <= n_hit;
        o_point_valid <= n_pv;
        o_cross_x     <= n_pv ? place(w_tagx[COORD_W-1:0], w_tagx[COORD_W], w_qx) : '0;
        o_cross_y     <= n_pv ? place(w_tagy[COORD_W-1:0], w_tagy[COORD_W], w_qy) : '0;
    end

endmodule

>>> rtl/core/segment_intersection_unit.sv
// Top level of the segment intersection unit: registers, front, queue and back.
//
// Accepts one segment pair per clock cycle (start high while busy is low) and
// returns exactly one result per pair, in order, on a one-cycle o_done strobe
// that cannot be held off. On the way to o_done a pair passes through five
// front registers for the cross products and range checks, one queue slot,
// the back end entry register, the 17-stage restoring divider that forms the
// rounded crossing point one bit per stage, and the result register.
// busy rises only when the queue plus front occupancy could overflow. With a
// QUEUE_DEPTH of at least 7 that never happens, because the back end drains
// every cycle, and pairs can follow back to back. Configuration writes are
// always ready and take effect at once; write them only while no pair is in
// flight.
module segment_intersection_unit #(
    parameter int COORD_FRAC_BITS = siu_pkg::COORD_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = siu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [siu_pkg::COORD_W-1:0]     i_p1_x,
    input  logic [siu_pkg::COORD_W-1:0]     i_p1_y,
    input  logic [siu_pkg::COORD_W-1:0]     i_p2_x,
    input  logic [siu_pkg::COORD_W-1:0]     i_p2_y,
    input  logic [siu_pkg::COORD_W-1:0]     i_q1_x,
    input  logic [siu_pkg::COORD_W-1:0]     i_q1_y,
    input  logic [siu_pkg::COORD_W-1:0]     i_q2_x,
    input  logic [siu_pkg::COORD_W-1:0]     i_q2_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [siu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [siu_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output logic                            o_done,
    output logic                            o_crosses,
    output logic                            o_point_valid,
    output logic [siu_pkg::COORD_W-1:0]     o_cross_x,
    output logic [siu_pkg::COORD_W-1:0]     o_cross_y
);
    import siu_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam int CEIL_RAW = 100 << COORD_FRAC_BITS;
    localparam logic [COORD_W-1:0] CEIL = COORD_W'((CEIL_RAW < 32767) ? CEIL_RAW : 32767);

    // Configuration registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orient_tol <= OTOL_RST;
            r_cfg.coord_tol  <= CTOL_RST;
            r_cfg.param_tol  <= PTOL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIENT_TOL: r_cfg.orient_tol <= i_cfg_data[OTOL_W-1:0];
                REG_COORD_TOL:  r_cfg.coord_tol  <= i_cfg_data[CTOL_W-1:0];
                REG_PARAM_TOL:  r_cfg.param_tol  <= i_cfg_data[PTOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Admission: front occupancy plus queue fill must leave a free slot
    logic               w_accept;
    logic               w_push, w_empty;
    t_qentry            w_in_entry, w_out_entry;
    logic [CNT_W-1:0]   w_count;
    logic [INFL_W-1:0]  w_inflight;
    logic [CNT_W:0]     w_load;

    assign w_load   = (CNT_W+1)'(w_count) + (CNT_W+1)'(w_inflight);
    assign busy     = w_load >= (CNT_W+1)'(QUEUE_DEPTH);
    assign w_accept = start && !busy;

    siu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_accept),
        .i_p1_x    (i_p1_x),
        .i_p1_y    (i_p1_y),
        .i_p2_x    (i_p2_x),
        .i_p2_y    (i_p2_y),
        .i_q1_x    (i_q1_x),
        .i_q1_y    (i_q1_y),
        .i_q2_x    (i_q2_x),
        .i_q2_y    (i_q2_y),
        .o_push    (w_push),
        .o_entry   (w_in_entry),
        .o_inflight(w_inflight)
    );

    siu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_in_entry),
        .i_pop  (!w_empty),
        .o_empty(w_empty),
        .o_entry(w_out_entry),
        .o_count(w_count)
    );

    siu_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (!w_empty),
        .i_entry      (w_out_entry),
        .o_done       (o_done),
        .o_crosses    (o_crosses),
        .o_point_valid(o_point_valid),
        .o_cross_x    (o_cross_x),
        .o_cross_y    (o_cross_y)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_point_valid) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("point fields not cleared for invalid point");

    a_point_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cross_x <= CEIL && o_cross_y <= CEIL))
        else $error("crossing point above saturation ceiling");

    a_done_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown({o_crosses, o_point_valid, o_cross_x, o_cross_y}))
        else $error("result fields unknown on a result transaction");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the segment intersection unit.
module tb_top;
    import siu_pkg::*;

    localparam int CEIL_COORD   = 25600;
    localparam int FULL_COORD   = 32767;
    localparam int SETTLE_CYC   = 30;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEMS_PER_PH = 270;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y;
    } t_seg_pair;

    typedef struct packed {
        logic               crosses;
        logic               point_valid;
        logic [COORD_W-1:0] cross_x;
        logic [COORD_W-1:0] cross_y;
    } t_crossing;

    // Predicts one crossing result per accepted pair and checks arrivals in order
    class t_crossing_board;
        t_crossing awaited[$];
        longint    otol, ctol, ptol;
        int        errors;

        function new();
            otol = 1; ctol = 1; ptol = 1; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_ORIENT_TOL: otol = data;
                REG_COORD_TOL:  ctol = data[CTOL_W-1:0];
                REG_PARAM_TOL:  ptol = data[PTOL_W-1:0];
                default: ;
            endcase
        endfunction

        function int band(longint v);
            if (v > otol) return 1;
            if (v < -otol) return -1;
            return 0;
        endfunction

        function int turn_sign(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy);
            return band((bx - ax) * (cy - ay) - (by - ay) * (cx - ax));
        endfunction

        function bit spans(longint a, longint b, longint c);
            longint lo, hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return (lo <= c + ctol) && (c <= hi + ctol);
        endfunction

        function bit param_in(longint num, longint den);
            longint scaled;
            scaled = num * 65536;
            return (scaled >= -ptol * den) && (scaled <= (65536 + ptol) * den);
        endfunction

        function longint round_div(longint num, longint den);
            if (num >= 0) return (num + den / 2) / den;
            return -((-num + den / 2) / den);
        endfunction

        function longint clamp_pct(longint v);
            if (v < 0) return 0;
            if (v > CEIL_COORD) return CEIL_COORD;
            return v;
        endfunction

        function t_crossing predict(t_seg_pair s);
            longint ax, ay, bx, by, cx, cy, dx, dy;
            longint rx, ry, sx, sy, qx, qy, den, tn, un;
            int o1, o2, o3, o4;
            t_crossing r;
            ax = s.p1_x; ay = s.p1_y; bx = s.p2_x; by = s.p2_y;
            cx = s.q1_x; cy = s.q1_y; dx = s.q2_x; dy = s.q2_y;
            o1 = turn_sign(ax, ay, bx, by, cx, cy);
            o2 = turn_sign(ax, ay, bx, by, dx, dy);
            o3 = turn_sign(cx, cy, dx, dy, ax, ay);
            o4 = turn_sign(cx, cy, dx, dy, bx, by);
            r = '0;
            r.crosses = (o1 != o2 && o3 != o4)
                || (o1 == 0 && spans(ax, bx, cx) && spans(ay, by, cy))
                || (o2 == 0 && spans(ax, bx, dx) && spans(ay, by, dy))
                || (o3 == 0 && spans(cx, dx, ax) && spans(cy, dy, ay))
                || (o4 == 0 && spans(cx, dx, bx) && spans(cy, dy, by));
            rx = bx - ax; ry = by - ay;
            sx = dx - cx; sy = dy - cy;
            qx = cx - ax; qy = cy - ay;
            den = rx * sy - ry * sx;
            tn  = qx * sy - qy * sx;
            un  = qx * ry - qy * rx;
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (den > otol && param_in(tn, den) && param_in(un, den)) begin
                r.point_valid = 1'b1;
                r.cross_x = COORD_W'(clamp_pct(ax + round_div(tn * rx, den)));
                r.cross_y = COORD_W'(clamp_pct(ay + round_div(tn * ry, den)));
            end
            return r;
        endfunction

        function void note_pair(t_seg_pair s);
            awaited.insert(awaited.size(), predict(s));
        endfunction

        function void check_result(t_crossing got);
            t_crossing want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.crosses !== want.crosses || got.point_valid !== want.point_valid
                || got.cross_x !== want.cross_x || got.cross_y !== want.cross_y) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, start, busy;
    logic               i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic               o_done, o_crosses, o_point_valid;
    logic [COORD_W-1:0] o_cross_x, o_cross_y;
    t_seg_pair          pair_in;
    t_crossing_board    board;
    int                 idle_pct;
    int                 quiet_cycles;

    segment_intersection_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p1_x(pair_in.p1_x), .i_p1_y(pair_in.p1_y),
        .i_p2_x(pair_in.p2_x), .i_p2_y(pair_in.p2_y),
        .i_q1_x(pair_in.q1_x), .i_q1_y(pair_in.q1_y),
        .i_q2_x(pair_in.q2_x), .i_q2_y(pair_in.q2_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_crosses(o_crosses), .o_point_valid(o_point_valid),
        .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: note accepted pairs, check results, register writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_pair(pair_in);
            if (o_done)
                board.check_result({o_crosses, o_point_valid, o_cross_x, o_cross_y});
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_seg_pair mk(int a, int b, int c, int d, int e, int f, int g, int h);
        t_seg_pair s;
        s = {COORD_W'(a), COORD_W'(b), COORD_W'(c), COORD_W'(d),
             COORD_W'(e), COORD_W'(f), COORD_W'(g), COORD_W'(h)};
        return s;
    endfunction

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > CEIL_COORD) ? CEIL_COORD : v;
    endfunction

    // Random pair: mostly plain segments, plus full-range, collinear, touching, parallel and tiny shapes
    function automatic t_seg_pair rand_pair();
        int kind, bx, by, dx, dy, k1, k2, ox, oy;
        t_seg_pair s;
        kind = $urandom_range(9);
        bx = $urandom_range(CEIL_COORD); by = $urandom_range(CEIL_COORD);
        dx = int'($urandom_range(400)) - 200; dy = int'($urandom_range(400)) - 200;
        k1 = int'($urandom_range(20)) - 10; k2 = int'($urandom_range(20)) - 10;
        ox = int'($urandom_range(6)) - 3; oy = int'($urandom_range(6)) - 3;
        case (kind)
            5: s = mk($urandom_range(FULL_COORD), $urandom_range(FULL_COORD),
                      $urandom_range(FULL_COORD), $urandom_range(FULL_COORD),
                      $urandom_range(FULL_COORD), $urandom_range(FULL_COORD),
                      $urandom_range(FULL_COORD), $urandom_range(FULL_COORD));
            6: s = mk(clip(bx), clip(by), clip(bx + 8 * dx), clip(by + 8 * dy),
                      clip(bx + k1 * dx), clip(by + k1 * dy),
                      clip(bx + k2 * dx), clip(by + k2 * dy));
            7: s = mk(clip(bx), clip(by), clip(bx + 20 * dx), clip(by + 20 * dy),
                      clip(bx + ox), clip(by + oy),
                      $urandom_range(CEIL_COORD), $urandom_range(CEIL_COORD));
            8: s = mk(clip(bx), clip(by), clip(bx + 30 * dx), clip(by + 30 * dy),
                      clip(bx + 7 * k1 + ox), clip(by + 7 * k2 + oy),
                      clip(bx + 7 * k1 + 30 * dx), clip(by + 7 * k2 + 30 * dy));
            9: s = mk($urandom_range(8), $urandom_range(8), $urandom_range(8),
                      $urandom_range(8), $urandom_range(8), $urandom_range(8),
                      $urandom_range(8), $urandom_range(8));
            default: s = mk($urandom_range(CEIL_COORD), $urandom_range(CEIL_COORD),
                            $urandom_range(CEIL_COORD), $urandom_range(CEIL_COORD),
                            $urandom_range(CEIL_COORD), $urandom_range(CEIL_COORD),
                            $urandom_range(CEIL_COORD), $urandom_range(CEIL_COORD));
        endcase
        return s;
    endfunction

    // Drive one pair, with a random idle gap ahead of it
    task automatic drive_pair(t_seg_pair s);
        int gap;
        gap = 0;
        while (gap < 25 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        pair_in <= s;
        do @(posedge i_clk); while (busy);
    endtask

    // Wait for all results, then for the pipeline to settle
    task automatic drain();
        @(negedge i_clk) start <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_tols(logic [CFG_DAT_W-1:0] o, logic [CFG_DAT_W-1:0] c,
                            logic [CFG_DAT_W-1:0] p);
        write_cfg(REG_ORIENT_TOL, o);
        write_cfg(REG_COORD_TOL, c);
        write_cfg(REG_PARAM_TOL, p);
    endtask

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        pair_in      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_ORIENT_TOL;
        i_cfg_data   = '0;
        idle_pct     = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed pairs at reset tolerances
        drive_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
        drive_pair(mk(FULL_COORD, FULL_COORD, FULL_COORD, FULL_COORD,
                      FULL_COORD, FULL_COORD, FULL_COORD, FULL_COORD));
        drive_pair(mk(0, 0, CEIL_COORD, CEIL_COORD, 0, CEIL_COORD, CEIL_COORD, 0));
        drive_pair(mk(0, 0, 1000, 1000, 0, 1000, 1000, 0));
        drive_pair(mk(0, 0, 2000, 0, 1000, 0, 1000, 500));       // T touch
        drive_pair(mk(0, 0, 2000, 0, 1000, 0, 3000, 0));         // collinear overlap
        drive_pair(mk(0, 0, 1000, 0, 2000, 0, 3000, 0));         // collinear apart
        drive_pair(mk(0, 0, 1000, 0, 1001, 0, 3000, 0));         // collinear, within slack
        drive_pair(mk(0, 0, 1000, 1000, 0, 10, 1000, 1010));     // parallel
        drive_pair(mk(500, 500, 1000, 0, 500, 500, 0, 0));       // shared endpoint
        drive_pair(mk(0, 0, 1000, 0, 1000, 100, 1000, -100 + 200)); // degenerate q, a point off p
        drive_pair(mk(0, 0, 999, 0, 1000, 0, 1000, 100));        // just past the end
        drive_pair(mk(FULL_COORD, 0, FULL_COORD, FULL_COORD, 0, 100, FULL_COORD, 100));
        drive_pair(mk(0, FULL_COORD, FULL_COORD, 0, 0, 0, FULL_COORD, FULL_COORD));
        drive_pair(mk(1, 0, 0, 1, 0, 0, 1, 1));                  // tiny, in tolerance band
        drive_pair(mk(CEIL_COORD, 0, 0, CEIL_COORD, 0, 0, 3, 3));
        drain();

        // Extreme and random tolerances, each with a burst of random pairs
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_tols(16'd0, 16'd0, 16'd0);
                1: set_tols(16'hFFFF, 16'h00FF, 16'h0FFF);
                2: set_tols(16'hFFFF, 16'hFF00, 16'hF000);
                default: set_tols(CFG_DAT_W'($urandom_range(16'hFFFF)),
                                  CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
            endcase
            if (ph == 3) write_cfg(REG_UNUSED, CFG_DAT_W'($urandom));
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 81;
                default: idle_pct = 37;
            endcase
            if (ph == 1 || ph == 2) begin
                drive_pair(mk(0, 0, 2000, 0, 1000, 255, 1000, 500));
                drive_pair(mk(0, 0, 1000, 0, 1255, 0, 3000, 0));
            end
            for (int n = 0; n < ITEMS_PER_PH; n++) drive_pair(rand_pair());
            drain();
        end

        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
